// ----- hdl/meu_pkg.sv -----
// Package for the modular exponentiation unit: widths, codes, shared types.
// No dependencies.
package meu_pkg;
    localparam int MOD_WIDTH = 16;
    localparam int EXP_WIDTH = 31;
    localparam int CASE_WIDTH = 2;
    localparam logic [CASE_WIDTH-1:0] CASE_FERMAT = 2'd0;
    localparam logic [CASE_WIDTH-1:0] CASE_EULER  = 2'd1;
    localparam logic [CASE_WIDTH-1:0] CASE_NONE   = 2'd2;

    // classified job handed from front to back
    typedef struct packed {
        logic [MOD_WIDTH-1:0]  base;
        logic [EXP_WIDTH-1:0]  exponent;
        logic [MOD_WIDTH-1:0]  modulus;
        logic [MOD_WIDTH-1:0]  exp_mod;   // exponent reduced modulo this; 0 means none
        logic [CASE_WIDTH-1:0] kind;
        logic                  bad;
    } job_t;
endpackage

// ----- hdl/meu_divider.sv -----
// Restoring divider (one instance each in front and back): remainder of a 64-bit
// dividend by a 32-bit divisor, one quotient bit per cycle. Depends on nothing.
module meu_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);
    logic [63:0] dvd_reg, dvd_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[31:0], dvd_reg[63]};
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[62:0], 1'b0};
            if (shifted >= {1'b0, dsr_reg})
                rem_next = shifted - {1'b0, dsr_reg};
            else
                rem_next = shifted;
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[31:0];
endmodule

// ----- hdl/meu_front.sv -----
// Front end: takes a transaction, runs trial division and gcd, classifies it.
// Depends on meu_pkg and meu_divider.
module meu_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [meu_pkg::MOD_WIDTH-1:0]  base,
    input  logic [meu_pkg::EXP_WIDTH-1:0]  exponent,
    input  logic [meu_pkg::MOD_WIDTH-1:0]  modulus,
    input  logic [meu_pkg::MOD_WIDTH-1:0]  totient,
    output meu_pkg::job_t                  job,
    output logic                           job_valid,
    input  logic                           job_ready
);
    localparam logic [2:0] S_IDLE = 3'd0, S_TRIAL = 3'd1, S_TWAIT = 3'd2,
                           S_GCD = 3'd3, S_GWAIT = 3'd4, S_OUT = 3'd5;
    logic [2:0] state_reg, state_next;
    meu_pkg::job_t job_reg, job_next;
    logic [meu_pkg::MOD_WIDTH:0] d_reg, d_next;       // trial divisor
    logic [meu_pkg::MOD_WIDTH-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [meu_pkg::MOD_WIDTH-1:0] bm_reg, bm_next;   // base mod m
    logic        dv_start;
    logic [63:0] dv_dividend;
    logic [31:0] dv_divisor;
    logic        dv_done;
    logic [31:0] dv_rem;
    logic [2*meu_pkg::MOD_WIDTH+1:0] dsq;
    logic        prime_ok;

    meu_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
        .divisor(dv_divisor), .done(dv_done), .remainder(dv_rem)
    );

    assign dsq = d_reg * d_reg;

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        d_next      = d_reg;
        ga_next     = ga_reg;
        gb_next     = gb_reg;
        bm_next     = bm_reg;
        dv_start    = 1'b0;
        dv_dividend = '0;
        dv_divisor  = '0;
        prime_ok    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    job_next.base     = base;
                    job_next.exponent = exponent;
                    job_next.modulus  = modulus;
                    job_next.exp_mod  = '0;
                    job_next.bad      = (modulus == '0);
                    job_next.kind     = meu_pkg::CASE_NONE;
                    d_next            = (meu_pkg::MOD_WIDTH+1)'(2);
                    // base mod m first (also gives multiple test)
                    if (modulus == '0)
                        state_next = S_OUT;
                    else
                    begin
                        dv_start    = 1'b1;
                        dv_dividend = 64'(base);
                        dv_divisor  = 32'(modulus);
                        state_next  = S_TWAIT;
                        bm_next     = '1;
                    end
                end
            end
            S_TRIAL:
            begin
                if (job_reg.modulus < 16'd2)
                    state_next = S_GCD;
                else if (dsq > (2*meu_pkg::MOD_WIDTH+2)'(job_reg.modulus))
                begin
                    prime_ok       = 1'b1;
                    job_next.kind  = meu_pkg::CASE_FERMAT;
                    job_next.exp_mod = (bm_reg != '0) ? job_reg.modulus - 1'b1 : '0;
                    state_next     = S_OUT;
                end
                else
                begin
                    dv_start    = 1'b1;
                    dv_dividend = 64'(job_reg.modulus);
                    dv_divisor  = 32'(d_reg);
                    state_next  = S_TWAIT;
                end
            end
            S_TWAIT:
            begin
                if (dv_done)
                begin
                    if (bm_reg == '1 && job_reg.modulus != '1)
                        bm_next = dv_rem[meu_pkg::MOD_WIDTH-1:0];
                    else if (bm_reg == '1)
                        bm_next = '0;
                    else if (dv_rem == '0)
                    begin
                        state_next = S_GCD;
                    end
                    else
                        d_next = d_reg + 1'b1;
                    if (bm_reg == '1 || dv_rem != '0)
                        state_next = S_TRIAL;
                    ga_next = job_reg.base;
                    gb_next = job_reg.modulus;
                end
            end
            S_GCD:
            begin
                if (gb_reg == '0)
                begin
                    if (ga_reg == 16'd1)
                    begin
                        job_next.kind    = meu_pkg::CASE_EULER;
                        job_next.exp_mod = totient;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    dv_start    = 1'b1;
                    dv_dividend = 64'(ga_reg);
                    dv_divisor  = 32'(gb_reg);
                    state_next  = S_GWAIT;
                end
            end
            S_GWAIT:
            begin
                if (dv_done)
                begin
                    ga_next    = gb_reg;
                    gb_next    = dv_rem[meu_pkg::MOD_WIDTH-1:0];
                    state_next = S_GCD;
                end
            end
            S_OUT:
            begin
                if (job_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        d_reg   <= d_next;
        ga_reg  <= ga_next;
        gb_reg  <= gb_next;
        bm_reg  <= bm_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign job       = job_reg;
    assign job_valid = (state_reg == S_OUT) && !prime_ok;
endmodule

// ----- hdl/meu_queue.sv -----
// Two-entry queue of classified jobs between front and back.
// Depends on meu_pkg.
module meu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  meu_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output meu_pkg::job_t rd_data
);
    meu_pkg::job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= ~wp_reg;
            if (do_rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ----- hdl/meu_back.sv -----
// Back end: optional exponent reduction and base reduction, then right-to-left square and multiply.
// Depends on meu_pkg and meu_divider.
module meu_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    output logic                            job_ready,
    input  meu_pkg::job_t                   job,
    output logic                            done,
    output logic [meu_pkg::MOD_WIDTH-1:0]   power_result,
    output logic [meu_pkg::CASE_WIDTH-1:0]  reduction_case,
    output logic                            bad_modulus
);
    localparam logic [2:0] S_IDLE = 3'd0, S_EWAIT = 3'd1, S_BWAIT = 3'd2,
                           S_STEP = 3'd3, S_MWAIT = 3'd4, S_SWAIT = 3'd5;
    logic [2:0] state_reg, state_next;
    meu_pkg::job_t job_reg, job_next;
    logic [meu_pkg::EXP_WIDTH-1:0] e_reg, e_next;
    logic [meu_pkg::MOD_WIDTH-1:0] b_reg, b_next, acc_reg, acc_next;
    logic done_reg, done_next;
    logic [meu_pkg::MOD_WIDTH-1:0] res_reg, res_next;
    logic        dv_start;
    logic [63:0] dv_dividend;
    logic [31:0] dv_divisor;
    logic        dv_done;
    logic [31:0] dv_rem;
    logic [2*meu_pkg::MOD_WIDTH-1:0] mul_prod;   // acc * b
    logic [2*meu_pkg::MOD_WIDTH-1:0] sq_prod;    // b * b

    meu_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
        .divisor(dv_divisor), .done(dv_done), .remainder(dv_rem)
    );

    assign mul_prod = acc_reg * b_reg;
    assign sq_prod  = b_reg * b_reg;

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        e_next      = e_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        dv_start    = 1'b0;
        dv_dividend = '0;
        dv_divisor  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_next = job;
                    e_next   = job.exponent;
                    acc_next = 16'd1;
                    if (job.bad)
                    begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end
                    else if (job.exp_mod != '0)
                    begin
                        dv_start    = 1'b1;
                        dv_dividend = 64'(job.exponent);
                        dv_divisor  = 32'(job.exp_mod);
                        state_next  = S_EWAIT;
                    end
                    else
                    begin
                        dv_start    = 1'b1;
                        dv_dividend = 64'(job.base);
                        dv_divisor  = 32'(job.modulus);
                        state_next  = S_BWAIT;
                    end
                end
            end
            S_EWAIT:
            begin
                if (dv_done)
                begin
                    e_next      = dv_rem[meu_pkg::EXP_WIDTH-1:0];
                    dv_start    = 1'b1;
                    dv_dividend = 64'(job_reg.base);
                    dv_divisor  = 32'(job_reg.modulus);
                    state_next  = S_BWAIT;
                end
            end
            S_BWAIT:
            begin
                if (dv_done)
                begin
                    b_next     = dv_rem[meu_pkg::MOD_WIDTH-1:0];
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (e_reg == '0)
                begin
                    res_next   = acc_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (e_reg[0])
                begin
                    dv_start    = 1'b1;
                    dv_dividend = 64'(mul_prod);
                    dv_divisor  = 32'(job_reg.modulus);
                    state_next  = S_MWAIT;
                end
                else
                begin
                    dv_start    = 1'b1;
                    dv_dividend = 64'(sq_prod);
                    dv_divisor  = 32'(job_reg.modulus);
                    state_next  = S_SWAIT;
                end
            end
            S_MWAIT:
            begin
                if (dv_done)
                begin
                    acc_next    = dv_rem[meu_pkg::MOD_WIDTH-1:0];
                    dv_start    = 1'b1;
                    dv_dividend = 64'(sq_prod);
                    dv_divisor  = 32'(job_reg.modulus);
                    state_next  = S_SWAIT;
                end
            end
            S_SWAIT:
            begin
                if (dv_done)
                begin
                    b_next     = dv_rem[meu_pkg::MOD_WIDTH-1:0];
                    e_next     = e_reg >> 1;
                    state_next = S_STEP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        e_reg    <= e_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign job_ready      = (state_reg == S_IDLE);
    assign done           = done_reg;
    assign power_result   = res_reg;
    assign reduction_case = job_reg.kind;
    assign bad_modulus    = job_reg.bad;
endmodule

// ----- hdl/modular_exponentiation_unit.sv -----
// Top level of the modular exponentiation unit.
// Depends on meu_pkg, meu_front, meu_queue, meu_back.

// One transaction computes base^exponent mod modulus with reduction_case and
// bad_modulus; results appear for one cycle with done and cannot be stalled.
// All modulo work goes through 64-step restoring dividers: the front classifies
// by trial division and gcd (up to roughly 256 + 24 divisions), the back reduces
// the exponent (when exp_mod is set) and runs up to 31 square-and-multiply steps
// of one or two divisions each. A zero modulus needs no division at all.
// The front classifies the next transaction while the back works on this one.
// The totient register (cfg_data, taken on cfg_valid) is sampled when the front
// finishes classification; write it only while the unit is idle.
module modular_exponentiation_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [meu_pkg::MOD_WIDTH-1:0]   base,
    input  logic [meu_pkg::EXP_WIDTH-1:0]   exponent,
    input  logic [meu_pkg::MOD_WIDTH-1:0]   modulus,
    output logic                            done,
    output logic [meu_pkg::MOD_WIDTH-1:0]   power_result,
    output logic [meu_pkg::CASE_WIDTH-1:0]  reduction_case,
    output logic                            bad_modulus,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [meu_pkg::MOD_WIDTH-1:0]   cfg_data
);
    logic [meu_pkg::MOD_WIDTH-1:0] totient_reg;
    meu_pkg::job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;
    logic in_ready;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            totient_reg <= '0;
        else if (cfg_valid)
            totient_reg <= cfg_data;
    end

    meu_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .in_ready(in_ready),
        .base(base), .exponent(exponent), .modulus(modulus), .totient(totient_reg),
        .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
    );

    meu_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_data(f_job), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    meu_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job_ready(q_ready),
        .job(q_job), .done(done), .power_result(power_result),
        .reduction_case(reduction_case), .bad_modulus(bad_modulus)
    );

    assign busy = !in_ready;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_modulus |-> power_result == '0) else $error("bad modulus result");
    a_bad_case: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_modulus |-> reduction_case == meu_pkg::CASE_NONE)
        else $error("bad modulus case");
    a_case_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> reduction_case <= meu_pkg::CASE_NONE) else $error("case out of range");
`endif
endmodule
